// File: design/ms_pkg.sv
// ----------------------------------------------------------------------------
// ms_pkg: shared types and constants for the merge sort engine
// Holds the controller state type, the memory write-enable bundle and the
// default sizes used by the top level.
// ----------------------------------------------------------------------------
package ms_pkg;

  // Width of one element
  localparam int DATA_W = 32;

  // Default number of elements one set may hold
  localparam int DEPTH_DEF = 32;

  // Controller states
  typedef enum logic [2:0] {
    ST_LOAD,   // take words into the store
    ST_PASS,   // start a merge pass or finish sorting
    ST_RUN,    // set up the bounds of the next pair of runs
    ST_RD,     // read both run heads
    ST_WR,     // compare heads and write the smaller one
    ST_ERD,    // read the next sorted element
    ST_ELD,    // load the output register
    ST_EHOLD   // hold the result word until it is taken
  } ms_state_t;

  // Write enables from the controller to the two buffers
  typedef struct packed {
    logic store_we;
    logic scratch_we;
  } ms_mem_ctl_t;

endpackage

// File: design/ms_ram.sv
// ----------------------------------------------------------------------------
// ms_ram: generic synchronous RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module ms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register both reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: design/ms_ctrl.sv
// ----------------------------------------------------------------------------
// ms_ctrl: load, merge and emit sequencer
// Writes incoming words into the store, runs bottom-up merge passes that
// ping-pong between store and scratch, then reads the sorted set out.
// ----------------------------------------------------------------------------
module ms_ctrl #(
  parameter int DEPTH = ms_pkg::DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // input channel
  input  logic                             valid,
  output logic                             ready,
  input  logic signed [ms_pkg::DATA_W-1:0] value,
  input  logic                             last,
  // result channel
  output logic                             res_valid,
  input  logic                             res_ready,
  output logic signed [ms_pkg::DATA_W-1:0] value_res,
  output logic                             last_res,
  output logic                             dropped,
  // buffer access
  output ms_pkg::ms_mem_ctl_t              mem_ctl,
  output logic [$clog2(DEPTH)-1:0]         waddr,
  output logic [ms_pkg::DATA_W-1:0]        wdata,
  output logic [$clog2(DEPTH)-1:0]         raddr_a,
  output logic [$clog2(DEPTH)-1:0]         raddr_b,
  input  logic [ms_pkg::DATA_W-1:0]        store_rd_a,
  input  logic [ms_pkg::DATA_W-1:0]        store_rd_b,
  input  logic [ms_pkg::DATA_W-1:0]        scratch_rd_a,
  input  logic [ms_pkg::DATA_W-1:0]        scratch_rd_b
);

  import ms_pkg::*;

  localparam int AW = $clog2(DEPTH);
  // wide enough for run bounds up to about three times DEPTH
  localparam int CW = AW + 2;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  ms_state_t state, state_next;

  logic [CW-1:0] cnt, cnt_next;     // elements held in the set
  logic          ovf, ovf_next;     // set saw more than DEPTH words
  logic [CW-1:0] w, w_next;         // run width of the current pass
  logic [CW-1:0] k, k_next;         // destination index
  logic [CW-1:0] a, a_next;         // left run head (also emit index)
  logic [CW-1:0] b, b_next;         // right run head
  logic [CW-1:0] mid, mid_next;     // end of left run
  logic [CW-1:0] hi, hi_next;       // end of right run
  logic          src_sel, src_sel_next; // 1: sorted data sits in scratch

  logic signed [DATA_W-1:0] value_res_next;
  logic          last_res_next, dropped_next, res_valid_next;

  logic              in_acc;
  logic [DATA_W-1:0] rd_a, rd_b;
  logic              take_a;
  logic [CW-1:0]     k_inc, run_mid, run_hi;

  assign in_acc  = valid && ready;
  assign rd_a    = src_sel ? scratch_rd_a : store_rd_a;
  assign rd_b    = src_sel ? scratch_rd_b : store_rd_b;
  assign take_a  = (a < mid) &&
                   ((b >= hi) || ($signed(rd_a) < $signed(rd_b)));
  assign k_inc   = k + ONE_C;
  assign run_mid = ((k + w) < cnt) ? (k + w) : cnt;
  assign run_hi  = ((k + (w << 1)) < cnt) ? (k + (w << 1)) : cnt;

  assign raddr_a = a[AW-1:0];
  assign raddr_b = b[AW-1:0];
  assign ready   = (state == ST_LOAD);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (in_acc && last) state_next = ST_PASS;
      end
      ST_PASS: begin
        state_next = (w < cnt) ? ST_RUN : ST_ERD;
      end
      ST_RUN:  state_next = ST_RD;
      ST_RD:   state_next = ST_WR;
      ST_WR: begin
        if (k_inc == cnt) begin
          state_next = ST_PASS;
        end else if (k_inc == hi) begin
          state_next = ST_RUN;
        end else begin
          state_next = ST_RD;
        end
      end
      ST_ERD:  state_next = ST_ELD;
      ST_ELD:  state_next = ST_EHOLD;
      ST_EHOLD: begin
        if (res_ready) begin
          state_next = ((a + ONE_C) == cnt) ? ST_LOAD : ST_ERD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    cnt_next       = cnt;
    ovf_next       = ovf;
    w_next         = w;
    k_next         = k;
    a_next         = a;
    b_next         = b;
    mid_next       = mid;
    hi_next        = hi;
    src_sel_next   = src_sel;
    value_res_next = value_res;
    last_res_next  = last_res;
    dropped_next   = dropped;
    res_valid_next = res_valid;
    mem_ctl        = '0;
    waddr          = k[AW-1:0];
    wdata          = take_a ? rd_a : rd_b;
    case (state)
      ST_LOAD: begin
        waddr = cnt[AW-1:0];
        wdata = value;
        if (in_acc) begin
          // store the word, or drop it when the store is full
          if (cnt < DEPTH_C) begin
            mem_ctl.store_we = 1'b1;
            cnt_next         = cnt + ONE_C;
          end else begin
            ovf_next = 1'b1;
          end
          w_next       = ONE_C;
          src_sel_next = 1'b0;
        end
      end
      ST_PASS: begin
        k_next  = '0;
        a_next  = '0;
        hi_next = '0;
      end
      ST_RUN: begin
        mid_next = run_mid;
        hi_next  = run_hi;
        a_next   = k;
        b_next   = run_mid;
      end
      ST_WR: begin
        // write the smaller head into the other buffer
        if (src_sel) begin
          mem_ctl.store_we = 1'b1;
        end else begin
          mem_ctl.scratch_we = 1'b1;
        end
        if (take_a) begin
          a_next = a + ONE_C;
        end else begin
          b_next = b + ONE_C;
        end
        k_next = k_inc;
        if (k_inc == cnt) begin
          src_sel_next = ~src_sel;
          w_next       = w << 1;
        end
      end
      ST_ELD: begin
        value_res_next = $signed(rd_a);
        last_res_next  = ((a + ONE_C) == cnt);
        dropped_next   = ovf;
        res_valid_next = 1'b1;
      end
      ST_EHOLD: begin
        if (res_ready) begin
          res_valid_next = 1'b0;
          a_next         = a + ONE_C;
          if ((a + ONE_C) == cnt) begin
            cnt_next = '0;
            ovf_next = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      cnt       <= '0;
      ovf       <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      ovf       <= ovf_next;
      res_valid <= res_valid_next;
    end
  end

  // Payload and index registers
  always_ff @(posedge clk) begin
    w         <= w_next;
    k         <= k_next;
    a         <= a_next;
    b         <= b_next;
    mid       <= mid_next;
    hi        <= hi_next;
    src_sel   <= src_sel_next;
    value_res <= value_res_next;
    last_res  <= last_res_next;
    dropped   <= dropped_next;
  end

endmodule

// File: design/merge_sort_engine_unit.sv
// ----------------------------------------------------------------------------
// merge_sort_engine_unit: merge sort engine for signed 32-bit sets
// Collects a set of words, sorts it ascending and returns it word by word.
// ----------------------------------------------------------------------------
// A set is loaded one word per cycle (ready is high while loading); the word
// flagged last closes it, and words past DEPTH are dropped and flagged on
// every result of that set. Sorting runs bottom-up merge passes between two
// RAMs over ceil(log2(n)) passes; each element of a pass is a head read, then
// a compare and write, and each run pair and each pass adds a setup step.
// Each sorted word is then read, loaded into the output register and held
// until the result side takes it. No new set is taken until the last result
// word is accepted.
module merge_sort_engine_unit #(
  parameter int DEPTH = ms_pkg::DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             valid,
  output logic                             ready,
  input  logic signed [ms_pkg::DATA_W-1:0] value,
  input  logic                             last,
  output logic                             res_valid,
  input  logic                             res_ready,
  output logic signed [ms_pkg::DATA_W-1:0] value_res,
  output logic                             last_res,
  output logic                             dropped
);

  import ms_pkg::*;

  localparam int AW = $clog2(DEPTH);

  ms_mem_ctl_t       mem_ctl;
  logic [AW-1:0]     waddr, raddr_a, raddr_b;
  logic [DATA_W-1:0] wdata;
  logic [DATA_W-1:0] store_rd_a, store_rd_b, scratch_rd_a, scratch_rd_b;

  // Sequencer
  ms_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .valid       (valid),
    .ready       (ready),
    .value       (value),
    .last        (last),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .value_res   (value_res),
    .last_res    (last_res),
    .dropped     (dropped),
    .mem_ctl     (mem_ctl),
    .waddr       (waddr),
    .wdata       (wdata),
    .raddr_a     (raddr_a),
    .raddr_b     (raddr_b),
    .store_rd_a  (store_rd_a),
    .store_rd_b  (store_rd_b),
    .scratch_rd_a(scratch_rd_a),
    .scratch_rd_b(scratch_rd_b)
  );

  // Input store, also a merge buffer
  ms_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_store (
    .clk    (clk),
    .we     (mem_ctl.store_we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr_a(raddr_a),
    .raddr_b(raddr_b),
    .rdata_a(store_rd_a),
    .rdata_b(store_rd_b)
  );

  // Scratch merge buffer
  ms_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_scratch (
    .clk    (clk),
    .we     (mem_ctl.scratch_we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr_a(raddr_a),
    .raddr_b(raddr_b),
    .rdata_a(scratch_rd_a),
    .rdata_b(scratch_rd_b)
  );

endmodule

// File: verif/merge_sort_checker.sv
// ----------------------------------------------------------------------------
// merge_sort_checker: scoreboard for the merge sort engine
// Watches both channels, collects each input set, predicts its sorted output
// and compares every result word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module merge_sort_checker #(
  parameter int DEPTH = ms_pkg::DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             valid,
  input  logic                             ready,
  input  logic signed [ms_pkg::DATA_W-1:0] value,
  input  logic                             last,
  input  logic                             res_valid,
  input  logic                             res_ready,
  input  logic signed [ms_pkg::DATA_W-1:0] value_res,
  input  logic                             last_res,
  input  logic                             dropped,
  output int                               errors,
  output int                               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [ms_pkg::DATA_W-1:0] word_t;

  typedef struct packed {
    word_t value;
    logic  last;
    logic  dropped;
  } sorted_word_t;

  word_t        set_words[$];
  logic         set_overflow = 1'b0;
  sorted_word_t sorted_words_q[$];
  int           fail_count = 0;

  // Sort the collected set ascending and queue one expected word per element
  function automatic void queue_sorted_set();
    word_t        sorted[$];
    word_t        key;
    sorted_word_t w;
    int           i;
    int           j;
    sorted = set_words;
    for (i = 1; i < sorted.size(); i++) begin
      key = sorted[i];
      j = i - 1;
      while (j >= 0 && sorted[j] > key) begin
        sorted[j + 1] = sorted[j];
        j--;
      end
      sorted[j + 1] = key;
    end
    for (i = 0; i < sorted.size(); i++) begin
      w.value   = sorted[i];
      w.last    = (i == sorted.size() - 1);
      w.dropped = set_overflow;
      sorted_words_q.push_back(w);
    end
  endfunction

  always @(posedge clk) begin
    sorted_word_t exp_w;
    if (rst) begin
      set_words.delete();
      sorted_words_q.delete();
      set_overflow = 1'b0;
    end else begin
      // Compare an accepted result word with the oldest prediction
      if (res_valid && res_ready) begin
        if (sorted_words_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result word, value_res %0d last_res %0b dropped %0b",
                   $time, value_res, last_res, dropped);
        end else begin
          exp_w = sorted_words_q.pop_front();
          if (value_res !== exp_w.value) begin
            fail_count++;
            $display("%0t: value_res mismatch, expected %0d, actual %0d",
                     $time, exp_w.value, value_res);
          end
          if (last_res !== exp_w.last) begin
            fail_count++;
            $display("%0t: last_res mismatch, expected %0b, actual %0b",
                     $time, exp_w.last, last_res);
          end
          if (dropped !== exp_w.dropped) begin
            fail_count++;
            $display("%0t: dropped mismatch, expected %0b, actual %0b",
                     $time, exp_w.dropped, dropped);
          end
        end
      end
      // Store an accepted input word, drop it once the set is full
      if (valid && ready) begin
        if (set_words.size() < DEPTH)
          set_words.push_back(value);
        else
          set_overflow = 1'b1;
        if (last) begin
          queue_sorted_set();
          set_words.delete();
          set_overflow = 1'b0;
        end
      end
    end
    errors  <= fail_count;
    pending <= sorted_words_q.size();
  end

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: top level for the merge sort engine
// Drives directed and random sets through the input channel under varying
// sender and receiver idling, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH          = ms_pkg::DEPTH_DEF;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_WORDS    = 42;

  localparam logic signed [ms_pkg::DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [ms_pkg::DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;

  logic                             clk       = 1'b0;
  logic                             rst       = 1'b1;
  logic                             valid     = 1'b0;
  logic                             ready;
  logic signed [ms_pkg::DATA_W-1:0] value     = '0;
  logic                             last      = 1'b0;
  logic                             res_valid;
  logic                             res_ready = 1'b0;
  logic signed [ms_pkg::DATA_W-1:0] value_res;
  logic                             last_res;
  logic                             dropped;

  int errors;
  int pending;
  int send_idle_pct = 29;
  int recv_idle_pct = 54;
  int quiet_cycles  = 0;
  int words_sent;

  merge_sort_engine_unit #(.DEPTH(DEPTH)) DUT (
    .clk       (clk),
    .rst       (rst),
    .valid     (valid),
    .ready     (ready),
    .value     (value),
    .last      (last),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .value_res (value_res),
    .last_res  (last_res),
    .dropped   (dropped)
  );

  merge_sort_checker #(.DEPTH(DEPTH)) u_checker (
    .clk       (clk),
    .rst       (rst),
    .valid     (valid),
    .ready     (ready),
    .value     (value),
    .last      (last),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .value_res (value_res),
    .last_res  (last_res),
    .dropped   (dropped),
    .errors    (errors),
    .pending   (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result side at random
  always @(posedge clk) begin
    res_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // End the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (valid && ready) || (res_valid && res_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("[merge_sort_engine_unit] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one word, idling first at random, and hold it until accepted
  task automatic send_word(input logic signed [ms_pkg::DATA_W-1:0] v, input logic l);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      valid <= 1'b0;
      @(posedge clk);
    end
    valid <= 1'b1;
    value <= v;
    last  <= l;
    @(negedge clk);
    while (!ready) @(negedge clk);
    @(posedge clk);
    words_sent++;
  endtask

  // Pick a word: extremes, a narrow band that forces ties, or any pattern
  function automatic logic signed [ms_pkg::DATA_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2, 3:    return int'($urandom_range(0, 8)) - 4;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_set(input int len);
    int k;
    for (k = 0; k < len; k++)
      send_word(pick_word(), (k == len - 1));
  endtask

  initial begin
    int phase;
    int len;
    words_sent = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed sets: single extremes, a reversed pair, ties, odd sizes
    send_word(WORD_MIN, 1'b1);
    send_word(WORD_MAX, 1'b1);
    send_word(WORD_MAX, 1'b0);
    send_word(WORD_MIN, 1'b1);
    send_word(0, 1'b0);
    send_word(-1, 1'b0);
    send_word(0, 1'b0);
    send_word(-1, 1'b1);
    send_word(100, 1'b0);
    send_word(7, 1'b0);
    send_word(7, 1'b0);
    send_word(-7, 1'b0);
    send_word(-100, 1'b1);
    send_word(-3, 1'b0);
    send_word(-2, 1'b0);
    send_word(1, 1'b0);
    send_word(2, 1'b1);
    send_word(5, 1'b0);
    send_word(WORD_MIN, 1'b0);
    send_word(5, 1'b1);
    send_word(32'sh5555_5555, 1'b0);
    send_word(32'shaaaa_aaaa, 1'b1);

    // Random sets in three idling phases, each opening with a large set
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 29;
          recv_idle_pct = 54;
          send_set(DEPTH);
        end
        1: begin
          send_idle_pct = 54;
          recv_idle_pct = 29;
          send_set(DEPTH + 1);
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          send_set(DEPTH + 5);
        end
      endcase
      words_sent = 0;
      while (words_sent < PHASE_WORDS - DEPTH) begin
        if ($urandom_range(0, 11) == 0)
          len = $urandom_range(DEPTH - 2, DEPTH + 2);
        else
          len = $urandom_range(1, 6);
        send_set(len);
      end
    end
    valid <= 1'b0;

    // Drain the remaining results, then let the engine sit idle before the verdict
    do @(negedge clk); while (pending != 0);
    repeat (30) @(posedge clk);
    @(negedge clk);
    if (errors == 0 && pending == 0)
      $display("[merge_sort_engine_unit] OK");
    else
      $display("[merge_sort_engine_unit] ERROR");
    $finish;
  end

endmodule

// File: files.f
design/ms_pkg.sv
design/ms_ram.sv
design/ms_ctrl.sv
design/merge_sort_engine_unit.sv
verif/merge_sort_checker.sv
verif/testbench.sv
